// ===== rtl/gtrav_pkg.sv =====
package gtrav_pkg;

  localparam int VTX_W = 6;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;
  localparam int CNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BFS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DFS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [ST_W-1:0] ST_VISIT = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Address source for the list head memory
  typedef enum logic [1:0] {
    HD_A,
    HD_B,
    HD_QV,
    HD_LW
  } hd_sel_t;

  // Source of a visited vertex
  typedef enum logic [1:0] {
    EM_A,
    EM_QV,
    EM_LW
  } emit_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      clear_graph;
    logic      hd_rd;
    hd_sel_t   hd_sel;
    logic      link_wr;
    logic      link_from_b;
    logic      run_init;
    logic      bfs_seed;
    logic      deq;
    logic      enq_w;
    logic      mark_w;
    logic      top_rd;
    logic      push_hd;
    logic      pop;
    logic      advance;
    logic      p_from_hd;
    logic      p_from_wl;
    logic      p_from_next;
    logic      lk_rd;
    logic      emit;
    emit_sel_t emit_sel;
    logic      flush;
    logic      err;
    logic      err_full;
  } gtrav_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             range_err;
    logic             full;
    logic             q_empty;
    logic             sp_zero;
    logic             p_null;
    logic             nb_new;
    logic             q_room;
    logic             s_room;
    logic             emit_ok;
    logic             out_free;
  } gtrav_stat_t;

endpackage

// ===== rtl/graph_bfs_dfs_traversal_core.sv =====
// Undirected graph store with breadth first and depth first traversal.
// Input stream: tuser carries the command (add edge, breadth first run,
// depth first run, clear); tdata carries the two vertices. Output stream:
// one transfer per visited vertex in visit order, tuser is the status,
// tlast marks the final result of an item. Errors give one result, vertex 0.
// The cfg channel writes the vertex count; it is always ready.
// The run time of a traversal grows with the visited vertices and the
// links walked. The controller steps the single-port head, link and work
// list memories, with at most one read per cycle.
// One item is worked at a time; s_axis_tready is high only between items.
// Reset empties every list and the link store and sets the count to 64;
// the output stream is empty after reset.
// When the receiver stalls, one result waits in the output register and
// one more in a holding register; the traversal then pauses until the
// output register is taken.
module graph_bfs_dfs_traversal_core
  import gtrav_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_LINKS    = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // src_vertex[5:0], dst_vertex[11:6], zeros
  input  logic [CMD_W-1:0] s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // vertex[5:0], zeros
  output logic [ST_W-1:0]  m_axis_tuser,  // status
  output logic             m_axis_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  gtrav_cmd_t       ctl;
  gtrav_stat_t      stat;
  logic [VTX_W-1:0] out_vertex;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {2'b00, out_vertex};

  gtrav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  gtrav_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_LINKS    (MAX_LINKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (s_axis_tuser),
    .in_src     (s_axis_tdata[5:0]),
    .in_dst     (s_axis_tdata[11:6]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_vertex (out_vertex),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

// ===== rtl/gtrav_dp.sv =====
module gtrav_dp
  import gtrav_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_LINKS    = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  gtrav_cmd_t        ctl,
  output gtrav_stat_t       stat,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [VTX_W-1:0]  in_src,
  input  logic [VTX_W-1:0]  in_dst,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VTX_W-1:0]  out_vertex,
  output logic [ST_W-1:0]   out_status,
  output logic              out_last
);

  localparam int PW  = $clog2(MAX_LINKS + 1);
  localparam int AW  = $clog2(MAX_LINKS);
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VPW = $clog2(MAX_VERTICES + 1);
  localparam int WLW = (PW > VTX_W) ? PW : VTX_W;
  localparam int LKW = VTX_W + PW;

  logic [CNT_W-1:0] vcount;
  logic [CNT_W-1:0] ceff;
  logic [CMD_W-1:0] cmd_q;
  logic [VTX_W-1:0] a_q;
  logic [VTX_W-1:0] b_q;

  logic [PW-1:0]    heads [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] hd_vld;
  logic [PW-1:0]    hd_q;
  logic [VTX_W-1:0] hd_addr;

  logic [LKW-1:0]   links [MAX_LINKS];
  logic [LKW-1:0]   lk_q;
  logic [PW-1:0]    used;
  logic [VTX_W-1:0] lk_vtx;
  logic [PW-1:0]    lk_next;

  logic [WLW-1:0]   wl [MAX_VERTICES];
  logic [WLW-1:0]   wl_q;
  logic [VPW-1:0]   ptr0;
  logic [VPW-1:0]   ptr1;
  logic [VPW-1:0]   top;

  logic [MAX_VERTICES-1:0] visited;
  logic [PW-1:0]    p;

  logic             pend_valid;
  logic [VTX_W-1:0] pend_v;
  logic [VTX_W-1:0] emit_v;
  logic             out_free;

  assign ceff    = (vcount > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount;
  assign lk_vtx  = lk_q[PW +: VTX_W];
  assign lk_next = lk_q[PW-1:0];
  assign top     = ptr1 - VPW'(1);
  assign out_free = !out_valid || out_ready;

  // Status toward the controller
  always_comb begin
    stat.item_cmd  = cmd_q;
    stat.range_err = ({1'b0, a_q} >= ceff) ||
                     ((cmd_q == CMD_ADD) && ({1'b0, b_q} >= ceff));
    stat.full      = ({1'b0, used} + (PW+1)'(2)) > (PW+1)'(MAX_LINKS);
    stat.q_empty   = (ptr0 == ptr1);
    stat.sp_zero   = (ptr1 == '0);
    stat.p_null    = (p == '0) || (p > PW'(MAX_LINKS));
    stat.nb_new    = ({1'b0, lk_vtx} < ceff) && !visited[lk_vtx[VIW-1:0]];
    stat.q_room    = ptr1 < VPW'(MAX_VERTICES);
    stat.s_room    = ptr1 < VPW'(MAX_VERTICES);
    stat.emit_ok   = !pend_valid || out_free;
    stat.out_free  = out_free;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
    end else if (cfg_valid) begin
      vcount <= cfg_data;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q <= in_cmd;
      a_q   <= in_src;
      b_q   <= in_dst;
    end
  end

  // Head memory address
  always_comb begin
    case (ctl.hd_sel)
      HD_A:    hd_addr = a_q;
      HD_B:    hd_addr = b_q;
      HD_QV:   hd_addr = wl_q[VTX_W-1:0];
      HD_LW:   hd_addr = lk_vtx;
      default: hd_addr = a_q;
    endcase
  end

  // List heads: valid bits cleared by reset and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      hd_vld <= '0;
    end else if (ctl.clear_graph) begin
      hd_vld <= '0;
    end else if (ctl.link_wr) begin
      hd_vld[ctl.link_from_b ? b_q[VIW-1:0] : a_q[VIW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link_wr) begin
      heads[ctl.link_from_b ? b_q[VIW-1:0] : a_q[VIW-1:0]] <= used + PW'(1);
    end
    if (ctl.hd_rd) begin
      hd_q <= hd_vld[hd_addr[VIW-1:0]] ? heads[hd_addr[VIW-1:0]] : '0;
    end
  end

  // Link store and fill count
  always_ff @(posedge clk) begin
    if (ctl.link_wr) begin
      links[used[AW-1:0]] <= {(ctl.link_from_b ? a_q : b_q), hd_q};
    end
    if (ctl.lk_rd) begin
      lk_q <= links[AW'(p - PW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctl.clear_graph) begin
      used <= '0;
    end else if (ctl.link_wr) begin
      used <= used + PW'(1);
    end
  end

  // Queue or stack storage
  always_ff @(posedge clk) begin
    if (ctl.bfs_seed) begin
      wl[0] <= WLW'(a_q);
    end else if (ctl.enq_w) begin
      wl[ptr1[VIW-1:0]] <= WLW'(lk_vtx);
    end else if (ctl.push_hd) begin
      wl[ptr1[VIW-1:0]] <= WLW'(hd_q);
    end else if (ctl.advance) begin
      wl[top[VIW-1:0]] <= WLW'(lk_next);
    end
    if (ctl.deq) begin
      wl_q <= wl[ptr0[VIW-1:0]];
    end else if (ctl.top_rd) begin
      wl_q <= wl[top[VIW-1:0]];
    end
  end

  // Queue head and tail, or stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr0 <= '0;
      ptr1 <= '0;
    end else if (ctl.run_init) begin
      ptr0 <= '0;
      ptr1 <= ctl.bfs_seed ? VPW'(1) : '0;
    end else begin
      if (ctl.deq) begin
        ptr0 <= ptr0 + VPW'(1);
      end
      if (ctl.enq_w || ctl.push_hd) begin
        ptr1 <= ptr1 + VPW'(1);
      end else if (ctl.pop) begin
        ptr1 <= top;
      end
    end
  end

  // Visited marks: only the start vertex is set at run start
  always_ff @(posedge clk) begin
    if (ctl.run_init) begin
      visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_q[VIW-1:0];
    end else if (ctl.mark_w) begin
      visited[lk_vtx[VIW-1:0]] <= 1'b1;
    end
  end

  // Link pointer being walked
  always_ff @(posedge clk) begin
    if (ctl.p_from_hd) begin
      p <= hd_q;
    end else if (ctl.p_from_wl) begin
      p <= wl_q[PW-1:0];
    end else if (ctl.p_from_next) begin
      p <= lk_next;
    end
  end

  always_comb begin
    case (ctl.emit_sel)
      EM_A:    emit_v = a_q;
      EM_QV:   emit_v = wl_q[VTX_W-1:0];
      EM_LW:   emit_v = lk_vtx;
      default: emit_v = a_q;
    endcase
  end

  // Hold one visit back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.emit) begin
        pend_valid <= 1'b1;
        pend_v     <= emit_v;
        if (pend_valid) begin
          out_valid  <= 1'b1;
          out_vertex <= pend_v;
          out_status <= ST_VISIT;
          out_last   <= 1'b0;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (ctl.flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
        out_vertex <= pend_v;
        out_status <= ST_VISIT;
        out_last   <= 1'b1;
      end else if (ctl.err) begin
        out_valid  <= 1'b1;
        out_vertex <= '0;
        out_status <= ctl.err_full ? ST_FULL : ST_RANGE;
        out_last   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/gtrav_ctrl.sv =====
module gtrav_ctrl
  import gtrav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gtrav_stat_t stat,
  output gtrav_cmd_t  ctl
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_A,
    S_RD_B,
    S_ADD_B,
    S_ERR_RANGE,
    S_ERR_FULL,
    S_B_POP,
    S_B_HEAD,
    S_B_PTR,
    S_B_LINK,
    S_B_NB,
    S_D_PUSH,
    S_D_TOP,
    S_D_LD,
    S_D_CHK,
    S_D_NB,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands and next state
  always_comb begin
    ctl        = '0;
    ctl.hd_sel = HD_A;
    ctl.emit_sel = EM_A;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.item_cmd == CMD_CLEAR) begin
          ctl.clear_graph = 1'b1;
          state_next = S_IDLE;
        end else if (stat.range_err) begin
          state_next = S_ERR_RANGE;
        end else if (stat.item_cmd == CMD_ADD) begin
          if (stat.full) begin
            state_next = S_ERR_FULL;
          end else begin
            ctl.hd_rd = 1'b1;
            state_next = S_ADD_A;
          end
        end else if (stat.item_cmd == CMD_BFS) begin
          ctl.run_init = 1'b1;
          ctl.bfs_seed = 1'b1;
          state_next = S_B_POP;
        end else begin
          ctl.run_init = 1'b1;
          ctl.emit = 1'b1;
          ctl.hd_rd = 1'b1;
          state_next = S_D_PUSH;
        end
      end
      S_ADD_A: begin
        ctl.link_wr = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        ctl.hd_rd = 1'b1;
        ctl.hd_sel = HD_B;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        ctl.link_wr = 1'b1;
        ctl.link_from_b = 1'b1;
        state_next = S_IDLE;
      end
      S_ERR_RANGE: begin
        if (stat.out_free) begin
          ctl.err = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR_FULL: begin
        if (stat.out_free) begin
          ctl.err = 1'b1;
          ctl.err_full = 1'b1;
          state_next = S_IDLE;
        end
      end
      // Breadth first: dequeue, visit, walk its list
      S_B_POP: begin
        if (stat.q_empty) begin
          state_next = S_FLUSH;
        end else begin
          ctl.deq = 1'b1;
          state_next = S_B_HEAD;
        end
      end
      S_B_HEAD: begin
        if (stat.emit_ok) begin
          ctl.emit = 1'b1;
          ctl.emit_sel = EM_QV;
          ctl.hd_rd = 1'b1;
          ctl.hd_sel = HD_QV;
          state_next = S_B_PTR;
        end
      end
      S_B_PTR: begin
        ctl.p_from_hd = 1'b1;
        state_next = S_B_LINK;
      end
      S_B_LINK: begin
        if (stat.p_null) begin
          state_next = S_B_POP;
        end else begin
          ctl.lk_rd = 1'b1;
          state_next = S_B_NB;
        end
      end
      S_B_NB: begin
        if (stat.nb_new) begin
          ctl.mark_w = 1'b1;
          ctl.enq_w = stat.q_room;
        end
        ctl.p_from_next = 1'b1;
        state_next = S_B_LINK;
      end
      // Depth first: stack of next-link pointers
      S_D_PUSH: begin
        ctl.push_hd = 1'b1;
        state_next = S_D_TOP;
      end
      S_D_TOP: begin
        if (stat.sp_zero) begin
          state_next = S_FLUSH;
        end else begin
          ctl.top_rd = 1'b1;
          state_next = S_D_LD;
        end
      end
      S_D_LD: begin
        ctl.p_from_wl = 1'b1;
        state_next = S_D_CHK;
      end
      S_D_CHK: begin
        if (stat.p_null) begin
          ctl.pop = 1'b1;
          state_next = S_D_TOP;
        end else begin
          ctl.lk_rd = 1'b1;
          state_next = S_D_NB;
        end
      end
      S_D_NB: begin
        if (stat.nb_new && stat.s_room) begin
          if (stat.emit_ok) begin
            ctl.advance = 1'b1;
            ctl.mark_w = 1'b1;
            ctl.emit = 1'b1;
            ctl.emit_sel = EM_LW;
            ctl.hd_rd = 1'b1;
            ctl.hd_sel = HD_LW;
            state_next = S_D_PUSH;
          end
        end else begin
          ctl.advance = 1'b1;
          state_next = S_D_TOP;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          ctl.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/tb_graph_bfs_dfs_traversal_core.sv =====
`timescale 1ns / 100ps

module tb_graph_bfs_dfs_traversal_core;
  import gtrav_pkg::*;

  localparam int NV = 64;
  localparam int NL = 512;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [ST_W-1:0]  status;
    logic             last;
  } visit_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    bit               has_exp;
    logic [ST_W-1:0]  exp_st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [ST_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = VCOUNT_RESET;

  graph_bfs_dfs_traversal_core dut (.*);

  always #5 clk = ~clk;

  // Shadow graph state
  logic [9:0]       head_q [NV];
  logic [VTX_W-1:0] lk_vtx [NL];
  logic [9:0]       lk_nxt [NL];
  int unsigned      used_links;
  int unsigned      vcount;
  visit_t           visits_due [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  bit rx_enable = 1'b0;
  bit rx_nostall = 1'b0;

  function automatic int unsigned eff_vcount();
    return (vcount > NV) ? NV : vcount;
  endfunction

  function automatic void push_visit(logic [VTX_W-1:0] v, logic [ST_W-1:0] st, bit l);
    visit_t r;
    r.vertex = v;
    r.status = st;
    r.last   = l;
    visits_due.push_back(r);
  endfunction

  function automatic void link_in(int unsigned from, int unsigned to);
    lk_vtx[used_links] = to[VTX_W-1:0];
    lk_nxt[used_links] = head_q[from];
    head_q[from] = 10'(used_links + 1);
    used_links++;
  endfunction

  // Compute the visit order for one item and queue it
  function automatic void predict_item(logic [CMD_W-1:0] cmd, int unsigned a,
                                       int unsigned b);
    int unsigned c;
    bit mark [NV];
    int unsigned wl [NV];
    int unsigned qh, qt, sp, p, w, v;
    int unsigned found [$];
    c = eff_vcount();
    if (cmd == CMD_CLEAR) begin
      foreach (head_q[i]) head_q[i] = '0;
      used_links = 0;
      return;
    end
    if (cmd == CMD_ADD) begin
      if (a >= c || b >= c) push_visit('0, ST_RANGE, 1'b1);
      else if (used_links + 2 > NL) push_visit('0, ST_FULL, 1'b1);
      else begin
        link_in(a, b);
        link_in(b, a);
      end
      return;
    end
    if (a >= c) begin
      push_visit('0, ST_RANGE, 1'b1);
      return;
    end
    foreach (mark[i]) mark[i] = 1'b0;
    if (cmd == CMD_BFS) begin
      qh = 0; qt = 0;
      wl[qt++] = a;
      mark[a] = 1'b1;
      while (qh < qt) begin
        v = wl[qh++];
        found.push_back(v);
        p = 32'(head_q[v]);
        while (p != 0) begin
          w = 32'(lk_vtx[p-1]);
          if (w < c && !mark[w]) begin
            mark[w] = 1'b1;
            if (qt < NV) wl[qt++] = w;
          end
          p = 32'(lk_nxt[p-1]);
        end
      end
    end else begin
      sp = 0;
      found.push_back(a);
      mark[a] = 1'b1;
      wl[sp++] = 32'(head_q[a]);
      while (sp > 0) begin
        p = wl[sp-1];
        if (p == 0) begin
          sp--;
          continue;
        end
        wl[sp-1] = 32'(lk_nxt[p-1]);
        w = 32'(lk_vtx[p-1]);
        if (w < c && !mark[w] && sp < NV) begin
          mark[w] = 1'b1;
          found.push_back(w);
          wl[sp++] = 32'(head_q[w]);
        end
      end
    end
    foreach (found[i]) push_visit(found[i][VTX_W-1:0], ST_VISIT, i == found.size() - 1);
  endfunction

  // Random gap length: mostly short, sometimes long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    visit_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (visits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result vertex=%0d status=%0d last=%0b", $time,
                 m_axis_tdata[5:0], m_axis_tuser, m_axis_tlast);
      end else begin
        e = visits_due.pop_front();
        if (m_axis_tdata !== {2'b00, e.vertex} || m_axis_tuser !== e.status
            || m_axis_tlast !== e.last) begin
          errors++;
          $display("%0t: mismatch expected vertex=%0d status=%0d last=%0b,",
                   $time, e.vertex, e.status, e.last);
          $display("    got vertex=%0d status=%0d last=%0b",
                   m_axis_tdata[5:0], m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // Receiver with random stalls
  initial begin
    int unsigned g;
    forever begin
      @(negedge clk);
      if (!rx_enable) m_axis_tready <= 1'b0;
      else if (rx_nostall) m_axis_tready <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // Drive one item on the next falling edge and hold it until the transfer
  task automatic drive_item(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] a,
                            logic [VTX_W-1:0] b);
    @(negedge clk);
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    predict_item(cmd, 32'(a), 32'(b));
    drive_item(cmd, a, b);
  endtask

  task automatic wait_drained();
    while (visits_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] val);
    wait_drained();
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    vcount = 32'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned r, c, a, b;
    r = $urandom_range(0, 99);
    c = (eff_vcount() == 0) ? 1 : eff_vcount();
    a = $urandom_range(0, c - 1);
    b = $urandom_range(0, c - 1);
    if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 63);
    if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 63);
    if (r < 60) send_item(CMD_ADD, 6'(a), 6'(b));
    else if (r < 77) send_item(CMD_BFS, 6'(a), 6'($urandom_range(0, 63)));
    else if (r < 94) send_item(CMD_DFS, 6'(a), 6'($urandom_range(0, 63)));
    else send_item(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  initial begin
    row_t plan [$];
    row_t rw;
    int unsigned g;
    int unsigned counts [5] = '{64, 1, 8, 127, 20};
    vcount = 32'(VCOUNT_RESET);
    used_links = 0;
    foreach (head_q[i]) head_q[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rx_enable = 1'b1;

    // Directed table: run on empty graph, extremes, self loop, chain, clear
    plan = '{
      '{CMD_BFS, 6'd63, 6'd0, 1'b1, ST_VISIT},
      '{CMD_DFS, 6'd0, 6'd0, 1'b1, ST_VISIT},
      '{CMD_ADD, 6'd0, 6'd63, 1'b0, ST_VISIT},
      '{CMD_ADD, 6'd5, 6'd5, 1'b0, ST_VISIT},
      '{CMD_ADD, 6'd0, 6'd5, 1'b0, ST_VISIT},
      '{CMD_ADD, 6'd63, 6'd42, 1'b0, ST_VISIT},
      '{CMD_ADD, 6'd5, 6'd21, 1'b0, ST_VISIT},
      '{CMD_ADD, 6'd21, 6'd42, 1'b0, ST_VISIT},
      '{CMD_BFS, 6'd0, 6'd0, 1'b0, ST_VISIT},
      '{CMD_DFS, 6'd0, 6'd0, 1'b0, ST_VISIT},
      '{CMD_DFS, 6'd42, 6'd63, 1'b0, ST_VISIT},
      '{CMD_BFS, 6'd5, 6'd0, 1'b0, ST_VISIT},
      '{CMD_CLEAR, 6'd63, 6'd63, 1'b0, ST_VISIT},
      '{CMD_BFS, 6'd0, 6'd0, 1'b1, ST_VISIT}
    };
    // Typed rows leave the graph as it is and give one final result
    foreach (plan[i]) begin
      rw = plan[i];
      if (rw.has_exp) begin
        push_visit((rw.exp_st == ST_VISIT) ? rw.a : '0, rw.exp_st, 1'b1);
        drive_item(rw.cmd, rw.a, rw.b);
      end else begin
        send_item(rw.cmd, rw.a, rw.b);
      end
    end

    // Small count: range errors and stale neighbours
    send_item(CMD_ADD, 6'd1, 6'd2);
    send_item(CMD_ADD, 6'd2, 6'd9);
    write_count(7'd4);
    send_item(CMD_ADD, 6'd4, 6'd0);
    send_item(CMD_ADD, 6'd0, 6'd63);
    send_item(CMD_BFS, 6'd4, 6'd0);
    send_item(CMD_DFS, 6'd2, 6'd0);
    send_item(CMD_BFS, 6'd1, 6'd0);
    write_count(7'd0);
    send_item(CMD_DFS, 6'd0, 6'd0);
    send_item(CMD_ADD, 6'd0, 6'd0);
    write_count(7'd64);

    // Random phases over several counts
    rx_nostall = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      write_count(7'(counts[ph]));
      rx_nostall = (ph == 2);
      for (int k = 0; k < 40; k++) begin
        random_item();
        if (k == 20) wait_drained();
        g = gap_len();
        repeat (g) @(negedge clk);
      end
      send_item(CMD_CLEAR, '0, '0);
    end

    wait_drained();
    repeat (100) @(negedge clk);
    $display("Ran %0d items and checked %0d results over vertex counts 0 to 127,",
             n_items, n_results);
    $display("including self loops, stale neighbours and range errors.");
    if (errors == 0 && visits_due.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
